// ----- hw/rtl/tbps_pkg.sv -----
// Shared types and result codes for the token bucket packet shaper.
`timescale 1ns / 1ps

package tbps_pkg;

    localparam int FIELD_W = 16;

    typedef enum logic [2:0] {
        EV_QUEUED        = 3'd0,
        EV_OVERSIZE      = 3'd1,
        EV_REFUSED       = 3'd2,
        EV_TOKEN_ADDED   = 3'd3,
        EV_TOKEN_DROPPED = 3'd4
    } t_event;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] tag;
        logic [FIELD_W-1:0] need;
    } t_entry;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry wr_entry;
    } t_q_ctrl;

    typedef struct packed {
        logic   empty;
        logic   full;
        t_entry head;
    } t_q_stat;

endpackage

// ----- hw/rtl/token_bucket_packet_shaper_unit.sv -----
// Top level of the token bucket packet shaper.
`timescale 1ns / 1ps

// Each input beat is either a token tick (s_axis_tuser = 0) or a packet
// arrival (s_axis_tuser = 1) whose tdata carries the token need and a tag.
// Every input beat produces exactly one output beat that reports the event,
// the packet released in that step if any, and the bucket level and queue
// count after the step.
// The bucket depth is written through i_cfg_we / i_cfg_wdata; the user must
// do so only while no beat is in flight, as the block does not enforce it; it
// resets to 10. An accepted beat's result is registered and shows on the master
// side in the following cycle. One beat is taken per cycle while m_axis_tready
// stays high; the bucket update, queue access and release decision happen in
// the accepting cycle, and the queue head entry is read ahead from the memory.
// While the receiver holds m_axis_tready low, the result stays in the output
// register and the slave side accepts nothing more; when it is taken, a new
// beat may be accepted in the same cycle.
// Reset empties the bucket and the queue and drops any pending output beat.
// The queue memory needs no clearing pass.
module token_bucket_packet_shaper_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // packet_tokens[15:0], packet_tag[31:16]
    input  logic        s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_res[2:0], released[3], released_tag[19:4], released_tokens[35:20],
    // bucket_level[51:36], queue_count[56:52], zero[63:57]
    output logic [63:0] m_axis_tdata
);
    import tbps_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

    logic [FIELD_W-1:0]     r_depth;
    logic [COUNT_WIDTH-1:0] r_tokens;
    logic [COUNT_WIDTH-1:0] n_tokens;
    logic [COUNT_WIDTH-1:0] tokens_inc;
    logic [FILL_W-1:0]      q_fill;
    logic [FILL_W-1:0]      n_fill;
    t_q_ctrl                q_ctrl;
    t_q_stat                q_stat;
    logic                   in_accept;
    logic [FIELD_W-1:0]     in_need;
    logic [FIELD_W-1:0]     in_tag;

    t_event                 n_event;
    logic                   n_rel;
    logic [FIELD_W-1:0]     n_rel_tag;
    logic [FIELD_W-1:0]     n_rel_tok;

    logic                   r_out_valid;
    t_event                 r_event;
    logic                   r_rel;
    logic [FIELD_W-1:0]     r_rel_tag;
    logic [FIELD_W-1:0]     r_rel_tok;
    logic [FIELD_W-1:0]     r_level;
    logic [4:0]             r_qcount;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_need       = s_axis_tdata[15:0];
    assign in_tag        = s_axis_tdata[31:16];
    assign tokens_inc    = r_tokens + 1'b1;

    always_comb begin
        n_tokens          = r_tokens;
        n_event           = EV_TOKEN_DROPPED;
        n_rel             = 1'b0;
        n_rel_tag         = '0;
        n_rel_tok         = '0;
        q_ctrl.push       = 1'b0;
        q_ctrl.pop        = 1'b0;
        q_ctrl.wr_entry.need = in_need;
        q_ctrl.wr_entry.tag  = in_tag;
        if (s_axis_tuser == FUNC_TICK) begin
            if (CMP_W'(r_tokens) >= CMP_W'(r_depth) || r_tokens == '1) begin
                n_event = EV_TOKEN_DROPPED;
            end else begin
                n_event  = EV_TOKEN_ADDED;
                n_tokens = tokens_inc;
                if (!q_stat.empty &&
                    CMP_W'(tokens_inc) >= CMP_W'(q_stat.head.need)) begin
                    n_tokens   = tokens_inc - COUNT_WIDTH'(q_stat.head.need);
                    n_rel      = 1'b1;
                    n_rel_tag  = q_stat.head.tag;
                    n_rel_tok  = q_stat.head.need;
                    q_ctrl.pop = in_accept;
                end
            end
        end else begin
            if (in_need > r_depth) begin
                n_event = EV_OVERSIZE;
            end else if (q_stat.full) begin
                n_event = EV_REFUSED;
            end else begin
                n_event = EV_QUEUED;
                if (q_stat.empty && CMP_W'(r_tokens) >= CMP_W'(in_need)) begin
                    n_tokens  = r_tokens - COUNT_WIDTH'(in_need);
                    n_rel     = 1'b1;
                    n_rel_tag = in_tag;
                    n_rel_tok = in_need;
                end else begin
                    q_ctrl.push = in_accept;
                end
            end
        end
    end

    always_comb begin
        n_fill = q_fill;
        if (q_ctrl.push) begin
            n_fill = q_fill + 1'b1;
        end else if (q_ctrl.pop) begin
            n_fill = q_fill - 1'b1;
        end
    end

    tbps_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .o_stat  (q_stat),
        .o_fill  (q_fill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= 16'd10;
            r_tokens    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_tokens    <= n_tokens;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_event   <= n_event;
            r_rel     <= n_rel;
            r_rel_tag <= n_rel_tag;
            r_rel_tok <= n_rel_tok;
            r_level   <= FIELD_W'(n_tokens);
            r_qcount  <= 5'(n_fill);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_qcount, r_level, r_rel_tok, r_rel_tag, r_rel, r_event};

    a_release_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rel) |-> (r_event == EV_TOKEN_ADDED || r_event == EV_QUEUED))
        else $error("release reported with a drop or refusal");

    a_no_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_rel) |-> (r_rel_tag == '0 && r_rel_tok == '0))
        else $error("release fields set without a release");

    a_arrival_no_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s_axis_tuser == FUNC_PACKET) |=> (r_tokens <= $past(r_tokens)))
        else $error("packet arrival raised the bucket level");

endmodule

// ----- hw/rtl/tbps_fifo.sv -----
// Waiting queue of the shaper: circular buffer with a registered head entry.
`timescale 1ns / 1ps

module tbps_fifo #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tbps_pkg::t_q_ctrl                  i_ctrl,
    output tbps_pkg::t_q_stat                  o_stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_fill
);
    import tbps_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [FILL_W-1:0]  r_fill;
    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   n_tail;
    logic [FILL_W-1:0]  n_fill;
    t_entry             r_rd_entry;
    t_entry             r_byp_entry;
    logic               r_byp;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head = i_ctrl.pop  ? next_slot(r_head) : r_head;
        n_tail = i_ctrl.push ? next_slot(r_tail) : r_tail;
        n_fill = r_fill;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            r_byp  <= i_ctrl.push && (r_tail == n_head);
        end
    end

    // The entry at the next head is read ahead into a register; a write to that
    // same slot is forwarded around the memory.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_tail] <= i_ctrl.wr_entry;
        end
        r_rd_entry  <= mem[n_head];
        r_byp_entry <= i_ctrl.wr_entry;
    end

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_stat.head  = r_byp ? r_byp_entry : r_rd_entry;
    assign o_fill       = r_fill;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> !o_stat.full || i_ctrl.pop)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> !o_stat.empty)
        else $error("pop from an empty queue");

    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

endmodule
